// ----- rtl/environment_alarm_fsm_core_assert.svh -----
// assertion macros shared by the environment alarm fsm rtl
// no dependencies; included inside module bodies
`ifndef ENVIRONMENT_ALARM_FSM_CORE_ASSERT_SVH
`define ENVIRONMENT_ALARM_FSM_CORE_ASSERT_SVH

// same-cycle implication under synchronous reset
`define EAFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication under synchronous reset
`define EAFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/eafc_pkg.sv -----
// types, constants and register map of the environment alarm fsm
// no dependencies
package eafc_pkg;

   localparam int TIME_W  = 32;
   localparam int LIGHT_W = 12;
   localparam int TEMP_W  = 15;
   localparam int HUM_W   = 14;
   localparam int HEAT_W  = 16;
   localparam int HOLD_W  = 20;
   localparam int MODE_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [LIGHT_W-1:0]   DARK_LIGHT_LEVEL    = 12'd500;
   localparam logic signed [15:0]   DARK_TEMP_OFFSET    = 16'sd200;
   localparam logic [TIME_W-1:0]    FAIL_RECOVERY_TIME  = 32'd10000;
   localparam logic [TIME_W-1:0]    SENSOR_TIMEOUT_TIME = 32'd5000;

   localparam logic KIND_UPDATE  = 1'b0;
   localparam logic KIND_INVALID = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE    = 3'd0,
      MODE_MONITOR = 3'd1,
      MODE_WARNING = 3'd2,
      MODE_ALERT   = 3'd3,
      MODE_FAIL    = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_WARN  = 3'd0,
      CSR_TEMP_ALERT = 3'd1,
      CSR_TEMP_SAFE  = 3'd2,
      CSR_HUM_WARN   = 3'd3,
      CSR_HUM_ALERT  = 3'd4,
      CSR_HUM_SAFE   = 3'd5,
      CSR_HEAT_WARN  = 3'd6,
      CSR_HOLD_TIME  = 3'd7
   } csr_index_type;

   localparam logic [TEMP_W-1:0] TEMP_WARN_RESET  = 15'd3000;
   localparam logic [TEMP_W-1:0] TEMP_ALERT_RESET = 15'd3500;
   localparam logic [TEMP_W-1:0] TEMP_SAFE_RESET  = 15'd2800;
   localparam logic [HUM_W-1:0]  HUM_WARN_RESET   = 14'd7000;
   localparam logic [HUM_W-1:0]  HUM_ALERT_RESET  = 14'd8000;
   localparam logic [HUM_W-1:0]  HUM_SAFE_RESET   = 14'd6000;
   localparam logic [HEAT_W-1:0] HEAT_WARN_RESET  = 16'd3200;
   localparam logic [HOLD_W-1:0] HOLD_TIME_RESET  = 20'd5000;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_warn_level;
      logic [TEMP_W-1:0] temp_alert_level;
      logic [TEMP_W-1:0] temp_safe_level;
      logic [HUM_W-1:0]  hum_warn_level;
      logic [HUM_W-1:0]  hum_alert_level;
      logic [HUM_W-1:0]  hum_safe_level;
      logic [HEAT_W-1:0] heat_warn_level;
      logic [HOLD_W-1:0] hold_time_ms;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic [TIME_W-1:0]  now_ms;
      logic [LIGHT_W-1:0] light;
      logic [TEMP_W-1:0]  avg_temp;
      logic [HUM_W-1:0]   avg_hum;
      logic [HEAT_W-1:0]  heat_index;
      logic               averages_valid;
      logic [TIME_W-1:0]  last_valid_ms;
   } req_type;

endpackage

// ----- rtl/eafc_csr.sv -----
// threshold and hold time registers with write port
// depends on eafc_pkg
module eafc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [eafc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [eafc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output eafc_pkg::cfg_type                cfg
);
   import eafc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP_WARN:  cfg_in.temp_warn_level  = csr_wdata[TEMP_W-1:0];
            CSR_TEMP_ALERT: cfg_in.temp_alert_level = csr_wdata[TEMP_W-1:0];
            CSR_TEMP_SAFE:  cfg_in.temp_safe_level  = csr_wdata[TEMP_W-1:0];
            CSR_HUM_WARN:   cfg_in.hum_warn_level   = csr_wdata[HUM_W-1:0];
            CSR_HUM_ALERT:  cfg_in.hum_alert_level  = csr_wdata[HUM_W-1:0];
            CSR_HUM_SAFE:   cfg_in.hum_safe_level   = csr_wdata[HUM_W-1:0];
            CSR_HEAT_WARN:  cfg_in.heat_warn_level  = csr_wdata[HEAT_W-1:0];
            CSR_HOLD_TIME:  cfg_in.hold_time_ms     = csr_wdata[HOLD_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_warn_level  <= TEMP_WARN_RESET;
         cfg_ff.temp_alert_level <= TEMP_ALERT_RESET;
         cfg_ff.temp_safe_level  <= TEMP_SAFE_RESET;
         cfg_ff.hum_warn_level   <= HUM_WARN_RESET;
         cfg_ff.hum_alert_level  <= HUM_ALERT_RESET;
         cfg_ff.hum_safe_level   <= HUM_SAFE_RESET;
         cfg_ff.heat_warn_level  <= HEAT_WARN_RESET;
         cfg_ff.hold_time_ms     <= HOLD_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/eafc_fsm.sv -----
// alarm mode state machine with safe-hold and fail-recovery timers
// depends on eafc_pkg and environment_alarm_fsm_core_assert.svh
module eafc_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  eafc_pkg::req_type   req,
   input  eafc_pkg::cfg_type   cfg,
   output eafc_pkg::mode_type  mode_in,
   output logic                changed_in
);
   import eafc_pkg::*;
   `include "environment_alarm_fsm_core_assert.svh"

   mode_type            mode_ff;
   logic [TIME_W-1:0]   safe_since_ff;
   logic                safe_armed_ff;
   logic [TIME_W-1:0]   fail_since_ff;
   logic                fail_armed_ff;

   logic [TIME_W-1:0]   safe_since_in;
   logic                safe_armed_in;
   logic [TIME_W-1:0]   fail_since_in;
   logic                fail_armed_in;

   logic                go;
   mode_type            go_mode;

   logic [TIME_W-1:0]   sensor_age;
   logic [TIME_W-1:0]   fail_age;
   logic [TIME_W-1:0]   safe_age;
   logic signed [15:0]  temp_ext;
   logic signed [15:0]  warn_t;
   logic                alert_c;
   logic                warn_c;
   logic                safe_c;

   always_comb begin
      temp_ext = $signed({req.avg_temp[TEMP_W-1], req.avg_temp});
      warn_t   = $signed({cfg.temp_warn_level[TEMP_W-1], cfg.temp_warn_level});
      // darkness lowers the warning temperature
      if (req.light < DARK_LIGHT_LEVEL) begin
         warn_t = warn_t - DARK_TEMP_OFFSET;
      end
      alert_c = (temp_ext > $signed({cfg.temp_alert_level[TEMP_W-1], cfg.temp_alert_level}))
                && (req.avg_hum > cfg.hum_alert_level);
      warn_c  = (temp_ext > warn_t)
                || (req.avg_hum > cfg.hum_warn_level)
                || ($signed(req.heat_index) > $signed(cfg.heat_warn_level));
      safe_c  = (temp_ext < $signed({cfg.temp_safe_level[TEMP_W-1], cfg.temp_safe_level}))
                && (req.avg_hum < cfg.hum_safe_level);
   end

   always_comb begin
      sensor_age    = req.now_ms - req.last_valid_ms;
      safe_since_in = safe_since_ff;
      safe_armed_in = safe_armed_ff;
      fail_since_in = fail_since_ff;
      fail_armed_in = fail_armed_ff;
      go            = 1'b0;
      go_mode       = mode_ff;
      mode_in       = mode_ff;
      changed_in    = 1'b0;

      if (req.kind == KIND_INVALID) begin
         if (sensor_age > SENSOR_TIMEOUT_TIME) begin
            go      = 1'b1;
            go_mode = MODE_FAIL;
         end
      end else if (mode_ff == MODE_IDLE) begin
         go      = 1'b1;
         go_mode = MODE_MONITOR;
      end else if (mode_ff == MODE_FAIL) begin
         if (!fail_armed_ff) begin
            fail_since_in = req.now_ms;
            fail_armed_in = 1'b1;
         end
      end else begin
         fail_armed_in = 1'b0;
         if (req.averages_valid) begin
            if (alert_c) begin
               go      = 1'b1;
               go_mode = MODE_ALERT;
            end else if (warn_c) begin
               go      = 1'b1;
               go_mode = MODE_WARNING;
            end else if (safe_c) begin
               if (!safe_armed_ff) begin
                  safe_since_in = req.now_ms;
                  safe_armed_in = 1'b1;
               end
            end else begin
               safe_armed_in = 1'b0;
            end
         end
      end

      // timer checks use the since value as armed in this same step
      fail_age = req.now_ms - fail_since_in;
      safe_age = req.now_ms - safe_since_in;
      if (req.kind == KIND_UPDATE && mode_ff == MODE_FAIL
          && fail_age > FAIL_RECOVERY_TIME) begin
         fail_armed_in = 1'b0;
         go            = 1'b1;
         go_mode       = MODE_MONITOR;
      end
      if (req.kind == KIND_UPDATE && mode_ff != MODE_IDLE && mode_ff != MODE_FAIL
          && req.averages_valid && !alert_c && !warn_c && safe_c
          && safe_age >= {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_time_ms}) begin
         go      = 1'b1;
         go_mode = MODE_MONITOR;
      end

      // any real mode change disarms the safe timer
      if (go && go_mode != mode_ff) begin
         mode_in       = go_mode;
         changed_in    = 1'b1;
         safe_armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         safe_since_ff <= '0;
         safe_armed_ff <= 1'b0;
         fail_since_ff <= '0;
         fail_armed_ff <= 1'b0;
      end else if (step) begin
         mode_ff       <= mode_in;
         safe_since_ff <= safe_since_in;
         safe_armed_ff <= safe_armed_in;
         fail_since_ff <= fail_since_in;
         fail_armed_ff <= fail_armed_in;
      end
   end

   `EAFC_ASSERT_NEXT(a_changed_means_new_mode, clock, reset, step,
      $past(changed_in) == (mode_ff != $past(mode_ff)))
   `EAFC_ASSERT_NEXT(a_change_disarms_safe, clock, reset, step && changed_in,
      !safe_armed_ff)
   `EAFC_ASSERT_NEXT(a_fail_update_arms_or_leaves, clock, reset,
      step && req.kind == KIND_UPDATE && mode_ff == MODE_FAIL,
      fail_armed_ff || mode_ff == MODE_MONITOR)

endmodule

// ----- rtl/environment_alarm_fsm_core.sv -----
// environment alarm fsm: request register, mode step, result register.
// flow: a request goes from the request register to the result register as it frees.
// throughput: one request per cycle while not stalled; the mode step uses registered state.
// stalls: the request register holds while the result register waits on rsp_ready.
// reset: pipeline empty, mode idle, timers unarmed, thresholds at their defaults.
// depends on eafc_pkg, eafc_csr, eafc_fsm and environment_alarm_fsm_core_assert.svh
module environment_alarm_fsm_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [eafc_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [eafc_pkg::LIGHT_W-1:0]       req_light,
   input  logic signed [eafc_pkg::TEMP_W-1:0] req_avg_temp,
   input  logic [eafc_pkg::HUM_W-1:0]         req_avg_hum,
   input  logic signed [eafc_pkg::HEAT_W-1:0] req_heat_index,
   input  logic                               req_averages_valid,
   input  logic [eafc_pkg::TIME_W-1:0]        req_last_valid_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [eafc_pkg::MODE_W-1:0]        rsp_mode,
   output logic                               rsp_busy_res,
   output logic                               rsp_changed,
   input  logic                               csr_wr_en,
   input  logic [eafc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eafc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import eafc_pkg::*;
   `include "environment_alarm_fsm_core_assert.svh"

   cfg_type   cfg;
   req_type   req_in;
   req_type   s1_req_ff;
   logic      s1_valid_ff;
   logic      s1_valid_in;
   logic      out_take;
   logic      s1_go;

   mode_type  mode_in;
   logic      changed_in;

   logic [MODE_W-1:0] rsp_mode_ff;
   logic              rsp_busy_ff;
   logic              rsp_changed_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   eafc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   eafc_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_go),
      .req        (s1_req_ff),
      .cfg        (cfg),
      .mode_in    (mode_in),
      .changed_in (changed_in)
   );

   always_comb begin
      req_in.kind           = req_kind;
      req_in.now_ms         = req_now_ms;
      req_in.light          = req_light;
      req_in.avg_temp       = req_avg_temp;
      req_in.avg_hum        = req_avg_hum;
      req_in.heat_index     = req_heat_index;
      req_in.averages_valid = req_averages_valid;
      req_in.last_valid_ms  = req_last_valid_ms;
   end

   // result register frees when empty or being taken
   assign out_take     = !rsp_valid_ff || rsp_ready;
   assign s1_go        = s1_valid_ff && out_take;
   assign req_ready    = !s1_valid_ff || s1_go;
   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_take ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_in;
      end
      if (s1_go) begin
         rsp_mode_ff    <= mode_in;
         rsp_busy_ff    <= (mode_in == MODE_WARNING) || (mode_in == MODE_ALERT);
         rsp_changed_ff <= changed_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mode     = rsp_mode_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_changed  = rsp_changed_ff;

   `EAFC_ASSERT_NEXT(a_stage_holds_on_stall, clock, reset, s1_valid_ff && !out_take,
      s1_valid_ff)
   `EAFC_ASSERT_NEXT(a_no_phantom_result, clock, reset, !s1_valid_ff && !rsp_valid_ff,
      !rsp_valid_ff)
   `EAFC_ASSERT_NOW(a_busy_matches_mode, clock, reset, rsp_valid_ff,
      rsp_busy_ff == (rsp_mode_ff == MODE_WARNING || rsp_mode_ff == MODE_ALERT))

endmodule

// ----- tb/sv/alarm_mode_checker.sv -----
// checker for environment_alarm_fsm_core: predicts mode, busy and changed for every
// accepted request and compares them in order with the result channel
// depends on eafc_pkg
`timescale 1ns / 1ps
module alarm_mode_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_kind,
   input  logic [eafc_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [eafc_pkg::LIGHT_W-1:0]       req_light,
   input  logic signed [eafc_pkg::TEMP_W-1:0] req_avg_temp,
   input  logic [eafc_pkg::HUM_W-1:0]         req_avg_hum,
   input  logic signed [eafc_pkg::HEAT_W-1:0] req_heat_index,
   input  logic                               req_averages_valid,
   input  logic [eafc_pkg::TIME_W-1:0]        req_last_valid_ms,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [eafc_pkg::MODE_W-1:0]        rsp_mode,
   input  logic                               rsp_busy_res,
   input  logic                               rsp_changed,
   input  logic                               csr_wr_en,
   input  logic [eafc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eafc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 fail_count,
   output int                                 pending_count
);
   import eafc_pkg::*;

   typedef struct packed {
      mode_type mode;
      logic     busy;
      logic     changed;
   } alarm_result_type;

   alarm_result_type expected_results[$];
   alarm_result_type want;
   int mismatches = 0;

   // threshold copies
   int temp_warn_lvl, temp_alert_lvl, temp_safe_lvl;
   int hum_warn_lvl, hum_alert_lvl, hum_safe_lvl;
   int heat_warn_lvl;
   logic [HOLD_W-1:0] hold_ms;

   // alarm state
   mode_type          alarm_mode;
   logic [TIME_W-1:0] safe_start, fail_start;
   logic              safe_timing, fail_timing;

   task automatic load_reset_values();
      temp_warn_lvl  = $signed(TEMP_WARN_RESET);
      temp_alert_lvl = $signed(TEMP_ALERT_RESET);
      temp_safe_lvl  = $signed(TEMP_SAFE_RESET);
      hum_warn_lvl   = HUM_WARN_RESET;
      hum_alert_lvl  = HUM_ALERT_RESET;
      hum_safe_lvl   = HUM_SAFE_RESET;
      heat_warn_lvl  = $signed(HEAT_WARN_RESET);
      hold_ms        = HOLD_TIME_RESET;
      alarm_mode     = MODE_IDLE;
      safe_start     = '0;
      safe_timing    = 1'b0;
      fail_start     = '0;
      fail_timing    = 1'b0;
   endtask

   task automatic write_level();
      case (csr_index_type'(csr_index))
         CSR_TEMP_WARN:  temp_warn_lvl  = $signed(csr_wdata[TEMP_W-1:0]);
         CSR_TEMP_ALERT: temp_alert_lvl = $signed(csr_wdata[TEMP_W-1:0]);
         CSR_TEMP_SAFE:  temp_safe_lvl  = $signed(csr_wdata[TEMP_W-1:0]);
         CSR_HUM_WARN:   hum_warn_lvl   = csr_wdata[HUM_W-1:0];
         CSR_HUM_ALERT:  hum_alert_lvl  = csr_wdata[HUM_W-1:0];
         CSR_HUM_SAFE:   hum_safe_lvl   = csr_wdata[HUM_W-1:0];
         CSR_HEAT_WARN:  heat_warn_lvl  = $signed(csr_wdata[HEAT_W-1:0]);
         CSR_HOLD_TIME:  hold_ms        = csr_wdata[HOLD_W-1:0];
         default: ;
      endcase
   endtask

   // a request for the mode already held leaves the safe timer alone
   function automatic logic move_to(mode_type target);
      if (target == alarm_mode) return 1'b0;
      alarm_mode  = target;
      safe_timing = 1'b0;
      return 1'b1;
   endfunction

   function automatic alarm_result_type next_alarm_result();
      logic              changed;
      logic [TIME_W-1:0] elapsed;
      int                temp_val, hum_val, heat_val, warn_temp;
      logic              alert_hit, warn_hit, safe_hit;
      alarm_result_type  res;
      changed  = 1'b0;
      temp_val = req_avg_temp;
      hum_val  = req_avg_hum;
      heat_val = req_heat_index;
      if (req_kind == KIND_INVALID) begin
         elapsed = req_now_ms - req_last_valid_ms;
         if (elapsed > SENSOR_TIMEOUT_TIME) changed = move_to(MODE_FAIL);
      end else if (alarm_mode == MODE_IDLE) begin
         changed = move_to(MODE_MONITOR);
      end else if (alarm_mode == MODE_FAIL) begin
         if (!fail_timing) begin
            fail_start  = req_now_ms;
            fail_timing = 1'b1;
         end
         elapsed = req_now_ms - fail_start;
         if (elapsed > FAIL_RECOVERY_TIME) begin
            fail_timing = 1'b0;
            changed     = move_to(MODE_MONITOR);
         end
      end else begin
         fail_timing = 1'b0;
         if (req_averages_valid) begin
            warn_temp = temp_warn_lvl;
            if (req_light < DARK_LIGHT_LEVEL) warn_temp -= int'(DARK_TEMP_OFFSET);
            alert_hit = (temp_val > temp_alert_lvl) && (hum_val > hum_alert_lvl);
            warn_hit  = (temp_val > warn_temp) || (hum_val > hum_warn_lvl)
                        || (heat_val > heat_warn_lvl);
            safe_hit  = (temp_val < temp_safe_lvl) && (hum_val < hum_safe_lvl);
            if (alert_hit) begin
               changed = move_to(MODE_ALERT);
            end else if (warn_hit) begin
               changed = move_to(MODE_WARNING);
            end else if (safe_hit) begin
               if (!safe_timing) begin
                  safe_start  = req_now_ms;
                  safe_timing = 1'b1;
               end
               elapsed = req_now_ms - safe_start;
               if (elapsed >= hold_ms) changed = move_to(MODE_MONITOR);
            end else begin
               safe_timing = 1'b0;
            end
         end
      end
      res.mode    = alarm_mode;
      res.busy    = (alarm_mode == MODE_WARNING) || (alarm_mode == MODE_ALERT);
      res.changed = changed;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         load_reset_values();
         expected_results.delete();
      end else begin
         if (csr_wr_en) write_level();
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with no request outstanding: mode %0d", $realtime,
                           rsp_mode);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mode !== want.mode || rsp_busy_res !== want.busy
                   || rsp_changed !== want.changed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch mode exp %0d got %0d, busy exp %0b got %0b, %s",
                              $realtime, want.mode, rsp_mode, want.busy, rsp_busy_res,
                              $sformatf("changed exp %0b got %0b", want.changed,
                                        rsp_changed));
               end
            end
         end
         if (req_valid && req_ready) expected_results.push_back(next_alarm_result());
      end
      fail_count    <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
// top of the environment_alarm_fsm_core testbench: clock, reset, requests, thresholds
// and the verdict; checking is done by alarm_mode_checker; depends on eafc_pkg
`timescale 1ns / 1ps
module testbench;
   import eafc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 117;

   typedef enum {
      LEVELS_LOWEST, LEVELS_HIGHEST, LEVELS_ORDERED, LEVELS_SCATTERED
   } level_style_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_kind = KIND_UPDATE;
   logic [TIME_W-1:0]         req_now_ms = '0;
   logic [LIGHT_W-1:0]        req_light = '0;
   logic signed [TEMP_W-1:0]  req_avg_temp = '0;
   logic [HUM_W-1:0]          req_avg_hum = '0;
   logic signed [HEAT_W-1:0]  req_heat_index = '0;
   logic                      req_averages_valid = 1'b0;
   logic [TIME_W-1:0]         req_last_valid_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [MODE_W-1:0]         rsp_mode;
   logic                      rsp_busy_res;
   logic                      rsp_changed;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int send_idle_pct = 10;
   int recv_idle_pct = 82;

   // stimulus time base and a mirror of the thresholds for shaping readings
   logic [TIME_W-1:0] sim_ms;
   int lv_tw = 3000, lv_ta = 3500, lv_ts = 2800;
   int lv_hw = 7000, lv_ha = 8000, lv_hs = 6000;
   int lv_heat = 3200;

   level_style_type phase_styles[6] = '{LEVELS_ORDERED, LEVELS_LOWEST, LEVELS_ORDERED,
                                        LEVELS_HIGHEST, LEVELS_SCATTERED, LEVELS_ORDERED};

   environment_alarm_fsm_core i_dut (.*);
   alarm_mode_checker i_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL environment_alarm_fsm_core");
         $finish;
      end
   end

   function automatic int rand_between(int lo, int hi);
      if (hi <= lo) return lo;
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int clamp_to(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // readings that sit on a threshold, the dark-shifted warning level or anywhere
   function automatic int pick_near(int lo, int hi, int warn, int alert, int safe);
      int jitter;
      jitter = int'($urandom_range(6)) - 3;
      case ($urandom_range(5))
         0: return warn + jitter;
         1: return alert + jitter;
         2: return safe + jitter;
         3: return rand_between(lo, hi);
         4: return rand_between(lo, safe);
         default: return warn - int'(DARK_TEMP_OFFSET) + jitter;
      endcase
   endfunction

   task automatic send_req(input logic kind, input logic [TIME_W-1:0] now_ms,
                           input logic [LIGHT_W-1:0] light, input int temp, input int hum,
                           input int heat, input logic avg_ok,
                           input logic [TIME_W-1:0] last_ms);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_now_ms         <= now_ms;
      req_light          <= light;
      req_avg_temp       <= temp[TEMP_W-1:0];
      req_avg_hum        <= hum[HUM_W-1:0];
      req_heat_index     <= heat[HEAT_W-1:0];
      req_averages_valid <= avg_ok;
      req_last_valid_ms  <= last_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic apply_levels(input int tw, input int ta, input int ts, input int hw,
                               input int ha, input int hs, input int heat, input int hold);
      lv_tw = tw; lv_ta = ta; lv_ts = ts;
      lv_hw = hw; lv_ha = ha; lv_hs = hs;
      lv_heat = heat;
      write_reg(CSR_TEMP_WARN, tw);
      write_reg(CSR_TEMP_ALERT, ta);
      write_reg(CSR_TEMP_SAFE, ts);
      write_reg(CSR_HUM_WARN, hw);
      write_reg(CSR_HUM_ALERT, ha);
      write_reg(CSR_HUM_SAFE, hs);
      write_reg(CSR_HEAT_WARN, heat);
      write_reg(CSR_HOLD_TIME, hold);
      csr_wr_en <= 1'b0;
   endtask

   task automatic choose_levels(input level_style_type style);
      int ts, tw, ta, hs, hw, ha, hold;
      hold = ($urandom_range(3) == 0) ? rand_between(0, 600000) : rand_between(0, 8000);
      case (style)
         LEVELS_LOWEST: apply_levels(-4000, -4000, -4000, 0, 0, 0, -10000, 0);
         LEVELS_HIGHEST: apply_levels(8500, 8500, 8500, 10000, 10000, 10000, 20000, 600000);
         LEVELS_ORDERED: begin
            ts = rand_between(-4000, 5000);
            tw = clamp_to(ts + rand_between(0, 1500), -4000, 8500);
            ta = clamp_to(tw + rand_between(0, 2000), -4000, 8500);
            hs = rand_between(0, 7000);
            hw = clamp_to(hs + rand_between(0, 1500), 0, 10000);
            ha = clamp_to(hw + rand_between(0, 1500), 0, 10000);
            apply_levels(tw, ta, ts, hw, ha, hs, rand_between(-2000, 8000), hold);
         end
         default:
            apply_levels(rand_between(-4000, 8500), rand_between(-4000, 8500),
                         rand_between(-4000, 8500), rand_between(0, 10000),
                         rand_between(0, 10000), rand_between(0, 10000),
                         rand_between(-10000, 20000), hold);
      endcase
   endtask

   task automatic random_request();
      int temp, hum, heat;
      logic [LIGHT_W-1:0] light;
      logic [TIME_W-1:0] last_ms;
      logic kind;
      case ($urandom_range(11))
         0, 1: ;
         8: sim_ms += $urandom_range(4000, 12000);
         9: sim_ms += $urandom_range(1, 700000);
         10: sim_ms += $urandom;
         default: sim_ms += $urandom_range(1, 3000);
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            // calm readings
            temp = rand_between(-4000, lv_ts - 1);
            hum  = rand_between(0, lv_hs - 1);
            heat = rand_between(-10000, lv_heat);
         end
         4, 5: begin
            // hot and humid
            temp = rand_between(lv_ta - 3, 8500);
            hum  = rand_between(lv_ha - 3, 10000);
            heat = rand_between(-10000, 20000);
         end
         default: begin
            temp = pick_near(-4000, 8500, lv_tw, lv_ta, lv_ts);
            hum  = pick_near(0, 10000, lv_hw, lv_ha, lv_hs);
            heat = pick_near(-10000, 20000, lv_heat, lv_heat, -10000);
         end
      endcase
      case ($urandom_range(4))
         0: light = LIGHT_W'(DARK_LIGHT_LEVEL - 3 + $urandom_range(6));
         1: light = '0;
         2: light = '1;
         default: light = LIGHT_W'($urandom_range(4095));
      endcase
      kind = ($urandom_range(99) < 8) ? KIND_INVALID : KIND_UPDATE;
      case ($urandom_range(3))
         0: last_ms = sim_ms - $urandom_range(4995, 5005);
         1: last_ms = sim_ms - $urandom_range(0, 4999);
         2: last_ms = sim_ms - $urandom_range(5001, 700000);
         default: last_ms = $urandom;
      endcase
      send_req(kind, sim_ms, light, clamp_to(temp, -4000, 8500), clamp_to(hum, 0, 10000),
               clamp_to(heat, -10000, 20000), $urandom_range(99) < 92, last_ms);
   endtask

   initial begin
      int sent;
      sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds; idle goes to monitor whatever the readings
      send_req(KIND_UPDATE, 32'd0, 12'd4095, 8500, 10000, 20000, 1'b0, 32'hFFFF_FFFF);
      // safe timer armed at time zero, not yet held long enough
      send_req(KIND_UPDATE, 32'd0, 12'd0, -4000, 0, -10000, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd4999, 12'd0, -4000, 0, -10000, 1'b1, 32'd0);
      // darkness lowers the warning temperature
      send_req(KIND_UPDATE, 32'd5000, 12'd499, 2801, 5000, 0, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd5500, 12'd500, 2801, 5000, 0, 1'b1, 32'd0);
      // safe held exactly for the hold time
      send_req(KIND_UPDATE, 32'd6000, 12'd4095, 2799, 5999, 3200, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd11000, 12'd4095, 2799, 5999, 3200, 1'b1, 32'd0);
      // alert needs both, then humidity alone warns
      send_req(KIND_UPDATE, 32'd12000, 12'd2048, 3501, 8001, 0, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd13000, 12'd2048, 3500, 8001, 0, 1'b1, 32'd0);
      // repeated warning keeps the safe timer running
      send_req(KIND_UPDATE, 32'd20000, 12'd2048, 1000, 1000, 0, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd21000, 12'd2048, 1000, 1000, 3201, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd25000, 12'd2048, 1000, 1000, 0, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd26000, 12'd1, 8500, 10000, 20000, 1'b0, 32'd0);
      // sensor timeout boundary
      send_req(KIND_INVALID, 32'd30000, 12'd0, 0, 0, 0, 1'b1, 32'd25000);
      send_req(KIND_INVALID, 32'd30001, 12'd0, 0, 0, 0, 1'b1, 32'd25000);
      send_req(KIND_INVALID, 32'd40000, 12'd0, 0, 0, 0, 1'b0, 32'd0);
      // recovery boundary
      send_req(KIND_UPDATE, 32'd40000, 12'd0, 0, 0, 0, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd50000, 12'd0, 0, 0, 0, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd50001, 12'd0, 0, 0, 0, 1'b1, 32'd0);
      // time differences across the wrap
      send_req(KIND_INVALID, 32'd100, 12'd0, 0, 0, 0, 1'b1, 32'hFFFF_EC78);
      send_req(KIND_UPDATE, 32'hFFFF_FFF0, 12'd0, 0, 0, 0, 1'b1, 32'd0);
      send_req(KIND_UPDATE, 32'd10000, 12'd0, 0, 0, 0, 1'b1, 32'd0);
      send_req(KIND_INVALID, 32'd5, 12'd0, 0, 0, 0, 1'b1, 32'd6);
      send_req(KIND_UPDATE, 32'd7, 12'd0, 0, 0, 0, 1'b1, 32'd0);

      foreach (phase_styles[p]) begin
         wait_results_done();
         choose_levels(phase_styles[p]);
         sim_ms = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(30000) : $urandom;
         repeat (PHASE_ITEMS) begin
            if (sent == 2 * PHASE_ITEMS) begin
               send_idle_pct = 82;
               recv_idle_pct = 10;
            end else if (sent == 4 * PHASE_ITEMS) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            random_request();
            sent++;
         end
      end

      wait_results_done();
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS environment_alarm_fsm_core");
      end else begin
         $display("FAIL environment_alarm_fsm_core");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/eafc_pkg.sv
rtl/eafc_csr.sv
rtl/eafc_fsm.sv
rtl/environment_alarm_fsm_core.sv
tb/sv/alarm_mode_checker.sv
tb/sv/testbench.sv
